// File: src/lcb_pkg.sv
package lcb_pkg;

    localparam int CARD_W      = 63;
    localparam int NUM_DIGITS  = 19;
    localparam int BCD_W       = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W   = $clog2(CARD_W);
    localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS + 1);
    localparam int IN_DATA_W   = ((CARD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    localparam logic [BIT_CNT_W-1:0]   LAST_BIT   = BIT_CNT_W'(CARD_W - 1);
    localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT = DIGIT_IDX_W'(NUM_DIGITS - 1);

    localparam logic [1:0] BRAND_INVALID    = 2'd0;
    localparam logic [1:0] BRAND_AMEX       = 2'd1;
    localparam logic [1:0] BRAND_MASTERCARD = 2'd2;
    localparam logic [1:0] BRAND_VISA       = 2'd3;

    localparam logic [4:0] AMEX_LEN  = 5'd15;
    localparam logic [4:0] MC_LEN    = 5'd16;
    localparam logic [4:0] VISA_LEN1 = 5'd13;
    localparam logic [4:0] VISA_LEN2 = 5'd16;

    typedef struct packed {
        logic                   load;
        logic                   conv_step;
        logic                   scan_step;
        logic                   emit;
        logic [DIGIT_IDX_W-1:0] digit_idx;
    } dp_cmd_t;

endpackage

// File: src/lcb_ctrl.sv
module lcb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             m_tready,
    output logic             m_tvalid,
    output lcb_pkg::dp_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t                          state_reg;
    logic [lcb_pkg::BIT_CNT_W-1:0]   bit_cnt_reg;
    logic [lcb_pkg::DIGIT_IDX_W-1:0] digit_cnt_reg;
    logic                            m_tvalid_reg;
    logic                            out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.conv_step = (state_reg == ST_CONV);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.emit      = (state_reg == ST_FINISH) && out_free;
        cmd.digit_idx = digit_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    bit_cnt_reg   <= '0;
                    digit_cnt_reg <= '0;
                    if (s_tvalid)
                        state_reg <= ST_CONV;
                end
                ST_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == lcb_pkg::LAST_BIT)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    digit_cnt_reg <= digit_cnt_reg + 1'b1;
                    if (digit_cnt_reg == lcb_pkg::LAST_DIGIT)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    // hold here while the previous result is still unclaimed
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: src/lcb_datapath.sv
module lcb_datapath (
    input  logic                         clk,
    input  logic [lcb_pkg::CARD_W-1:0]   card_value,
    input  lcb_pkg::dp_cmd_t             cmd,
    output logic                         luhn_ok,
    output logic [4:0]                   card_len,
    output logic [1:0]                   brand
);

    logic [lcb_pkg::CARD_W-1:0] bin_reg;
    logic [lcb_pkg::BCD_W-1:0]  bcd_reg;
    logic [lcb_pkg::BCD_W-1:0]  bcd_adj;
    logic [3:0]                 sum_reg;
    logic                       dbl_reg;
    logic [3:0]                 prev_reg;
    logic [3:0]                 lead_hi_reg;
    logic [3:0]                 lead_lo_reg;
    logic [4:0]                 cnt_reg;
    logic                       luhn_ok_reg;
    logic [4:0]                 card_len_reg;
    logic [1:0]                 brand_reg;

    logic [3:0] cur_digit;
    logic [4:0] weighted;
    logic [4:0] sum_raw;
    logic [3:0] sum_next;
    logic       ok_now;
    logic [1:0] brand_next;

    // add-3 correction on every bcd digit ahead of the shift
    always_comb
    begin
        for (int i = 0; i < lcb_pkg::NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign cur_digit = bcd_reg[3:0];

    always_comb
    begin
        if (dbl_reg)
        begin
            weighted = {cur_digit, 1'b0};
            if (weighted > 5'd9)
                weighted = weighted - 5'd9;
        end
        else
        begin
            weighted = {1'b0, cur_digit};
        end
        sum_raw = {1'b0, sum_reg} + weighted;
        if (sum_raw >= 5'd10)
            sum_next = 4'(sum_raw - 5'd10);
        else
            sum_next = sum_raw[3:0];
    end

    assign ok_now = (sum_reg == 4'd0);

    always_comb
    begin
        brand_next = lcb_pkg::BRAND_INVALID;
        if (ok_now)
        begin
            priority if (cnt_reg == lcb_pkg::AMEX_LEN && lead_hi_reg == 4'd3
                         && (lead_lo_reg == 4'd4 || lead_lo_reg == 4'd7))
                brand_next = lcb_pkg::BRAND_AMEX;
            else if (cnt_reg == lcb_pkg::MC_LEN && lead_hi_reg == 4'd5
                     && lead_lo_reg >= 4'd1 && lead_lo_reg <= 4'd5)
                brand_next = lcb_pkg::BRAND_MASTERCARD;
            else if ((cnt_reg == lcb_pkg::VISA_LEN1 || cnt_reg == lcb_pkg::VISA_LEN2)
                     && lead_hi_reg == 4'd4)
                brand_next = lcb_pkg::BRAND_VISA;
            else
                brand_next = lcb_pkg::BRAND_INVALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg     <= card_value;
            bcd_reg     <= '0;
            sum_reg     <= '0;
            dbl_reg     <= 1'b0;
            prev_reg    <= '0;
            lead_hi_reg <= '0;
            lead_lo_reg <= '0;
            cnt_reg     <= '0;
        end
        else if (cmd.conv_step)
        begin
            bcd_reg <= {bcd_adj[lcb_pkg::BCD_W-2:0], bin_reg[lcb_pkg::CARD_W-1]};
            bin_reg <= {bin_reg[lcb_pkg::CARD_W-2:0], 1'b0};
        end
        else if (cmd.scan_step)
        begin
            // least significant digit first; the highest nonzero one sets length and prefix
            bcd_reg  <= {4'd0, bcd_reg[lcb_pkg::BCD_W-1:4]};
            sum_reg  <= sum_next;
            dbl_reg  <= !dbl_reg;
            prev_reg <= cur_digit;
            if (cur_digit != 4'd0)
            begin
                cnt_reg     <= 5'(cmd.digit_idx) + 5'd1;
                lead_hi_reg <= cur_digit;
                lead_lo_reg <= prev_reg;
            end
        end
        if (cmd.emit)
        begin
            luhn_ok_reg  <= ok_now;
            card_len_reg <= cnt_reg;
            brand_reg    <= brand_next;
        end
    end

    assign luhn_ok  = luhn_ok_reg;
    assign card_len = card_len_reg;
    assign brand    = brand_reg;

endmodule

// File: src/luhn_card_brand_check_unit.sv
// luhn check and card brand recognition on a binary card number
//
// input channel s_*: one beat carries a card number (63 bits, zero padded
// to 64). output channel m_*: one beat per input carries the luhn flag,
// the decimal digit count and the brand code.
//
// each number is converted to bcd one bit per cycle by the shift-and-add-3
// loop, then its 19 digits are scanned one per cycle for the weighted digit
// sum, the length and the two leading digits, then the result register is
// loaded once it is free.
//
// s_tready is high only while no number is being worked on. a finished
// result waits in the output register, so the next number is accepted and
// converted while the receiver stalls; only its own result waits for the
// register to be freed.
//
// reset clears the controller: no result pending, input ready.
module luhn_card_brand_check_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lcb_pkg::IN_DATA_W-1:0]    s_tdata,   // [62:0] card_value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lcb_pkg::OUT_DATA_W-1:0]   m_tdata    // [0] luhn_ok, [5:1] card_len,
                                                        // [7:6] brand
);

    lcb_pkg::dp_cmd_t cmd;
    logic             luhn_ok;
    logic [4:0]       card_len;
    logic [1:0]       brand;

    lcb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    lcb_datapath u_datapath (
        .clk        (clk),
        .card_value (s_tdata[lcb_pkg::CARD_W-1:0]),
        .cmd        (cmd),
        .luhn_ok    (luhn_ok),
        .card_len   (card_len),
        .brand      (brand)
    );

    assign m_tdata = {brand, card_len, luhn_ok};

endmodule
